// ===== rtl/sitd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared widths, character codes and the control bundle of the digit cells.
// ----------------------------------------------------------------------------
package sitd_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
   localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic move;
   } cell_ctrl_type;

endpackage

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed 32-bit integer to decimal ASCII text, one character per result.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_value and raise start while busy is low; the item is taken at
//   that clock edge and busy stays high until the last character is out.
//   Characters appear on rsp_character with rsp_strobe high for one cycle
//   each, most significant first: '-' for negative values, then the digits
//   without leading zeros. rsp_last marks the final character. Zero gives
//   the single character '0'.
// Timing:
//   The magnitude is shifted through a row of ten BCD digit cells, one bit
//   per cycle for all 32 bits, then leading zero digits are shifted out at
//   one per cycle, then the characters leave at one per cycle.
//   The receiver cannot stall: each character is valid for one cycle only.
// Reset:
//   Synchronous reset returns the block to idle and drops rsp_strobe.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top
   import sitd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_strobe,
   output logic [CHAR_W-1:0]   rsp_character,
   output logic                rsp_last
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DABBLE = 3'd1;
   localparam logic [2:0] ST_SKIP   = 3'd2;
   localparam logic [2:0] ST_SIGN   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                 strobe_ff, strobe_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;

   cell_ctrl_type        ctrl;
   logic                 accept;
   logic [NUM_DIGITS:0]  bit_chain;
   digit_type            digits [NUM_DIGITS];
   digit_type            top_digit;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign top_digit = digits[NUM_DIGITS-1];
   assign bit_chain[0] = mag_ff[VALUE_W-1];

   genvar g;
   generate
      for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
         digit_type lower;
         if (g == 0) begin : g_first
            assign lower = '0;
         end else begin : g_rest
            assign lower = digits[g-1];
         end
         sitd_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .bit_in   (bit_chain[g]),
            .digit_in (lower),
            .bit_out  (bit_chain[g+1]),
            .digit    (digits[g])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      strobe_in  = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      ctrl       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in     = req_value[VALUE_W-1];
               mag_in     = req_value[VALUE_W-1] ? (VALUE_W'(0) - req_value) : req_value;
               bit_cnt_in = '0;
               ctrl.clear = 1'b1;
               state_in   = ST_DABBLE;
            end
         end
         ST_DABBLE: begin
            ctrl.dabble = 1'b1;
            mag_in      = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in  = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               dig_cnt_in = DIG_CNT_W'(NUM_DIGITS);
               state_in   = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && dig_cnt_ff > DIG_CNT_W'(1)) begin
               ctrl.move  = 1'b1;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CHAR_MINUS;
            last_in   = 1'b0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in  = 1'b1;
            char_in    = CHAR_ZERO + CHAR_W'(top_digit);
            last_in    = (dig_cnt_ff == DIG_CNT_W'(1));
            ctrl.move  = 1'b1;
            dig_cnt_in = dig_cnt_ff - 1'b1;
            if (dig_cnt_ff == DIG_CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_character == CHAR_MINUS) ||
                     (rsp_character >= CHAR_ZERO &&
                      rsp_character <= CHAR_ZERO + CHAR_W'(DIGIT_MAX)))
      else $error("illegal character on result");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("character right after last");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_strobe)
      else $error("accepted item did not start conversion");

   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && dig_cnt_ff > DIG_CNT_W'(1) &&
       $past(state_ff) != ST_EMIT) |-> top_digit != '0)
      else $error("leading zero reached output");

endmodule

// ===== rtl/sitd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_cell
// One decimal digit of the conversion row: add-3 and shift during
// conversion, take the lower neighbor's digit during output.
// ----------------------------------------------------------------------------
module sitd_cell
   import sitd_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          bit_in,
   input  digit_type     digit_in,
   output logic          bit_out,
   output digit_type     digit
);

   digit_type digit_ff;
   digit_type digit_in_nxt;
   digit_type adj;

   always_comb begin
      adj = (digit_ff >= DABBLE_MIN) ? digit_ff + DABBLE_ADD : digit_ff;
   end

   assign bit_out = adj[DIGIT_W-1];
   assign digit   = digit_ff;

   always_comb begin
      digit_in_nxt = digit_ff;
      if (ctrl.clear) begin
         digit_in_nxt = '0;
      end else if (ctrl.dabble) begin
         digit_in_nxt = {adj[DIGIT_W-2:0], bit_in};
      end else if (ctrl.move) begin
         digit_in_nxt = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_nxt;
   end

endmodule
